>>> design/jcpf_pkg.sv
// ----------------------------------------------------------------------------
// Jump-confirmed position filter package
// Payload types, status codes, register map and reset values shared by the
// filter RTL.
// ----------------------------------------------------------------------------
`default_nettype none

package jcpf_pkg;

   // Field widths
   localparam int POS_W    = 24;               // signed Q8.16 position
   localparam int TOL_W    = 23;               // unsigned Q7.16 tolerance
   localparam int CNT_W    = 8;                // confirmation counter
   localparam int SQ_W     = 2 * TOL_W;        // square of a tolerance
   localparam int SUM_W    = SQ_W + 2;         // sum of three squares
   localparam int CSR_AW   = 4;                // byte address, 4 registers
   localparam int CSR_DW   = 32;

   // Result status codes
   typedef enum logic [2:0] {
      STATUS_NO_TARGET     = 3'd0,
      STATUS_UNCHANGED     = 3'd1,
      STATUS_PUBLISHED     = 3'd2,
      STATUS_NEW_CANDIDATE = 3'd3,
      STATUS_CONFIRMING    = 3'd4
   } status_type;

   // Register map (word index = paddr[3:2])
   typedef enum logic [1:0] {
      REG_CHANGE_TOL = 2'd0,
      REG_JUMP_THR   = 2'd1,
      REG_CAND_TOL   = 2'd2,
      REG_REQ_CONF   = 2'd3
   } csr_index_type;

   // Register reset values
   localparam logic [TOL_W-1:0] CHANGE_TOL_RESET = TOL_W'(655);
   localparam logic [TOL_W-1:0] JUMP_THR_RESET   = TOL_W'(32768);
   localparam logic [TOL_W-1:0] CAND_TOL_RESET   = TOL_W'(13107);
   localparam logic [CNT_W-1:0] REQ_CONF_RESET   = CNT_W'(3);
   localparam logic [SQ_W-1:0]  JUMP_THR_SQ_RESET =
      SQ_W'(JUMP_THR_RESET) * SQ_W'(JUMP_THR_RESET);
   localparam logic [SQ_W-1:0]  CAND_TOL_SQ_RESET =
      SQ_W'(CAND_TOL_RESET) * SQ_W'(CAND_TOL_RESET);

   localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

   // Input transaction
   typedef struct packed {
      logic                    target_present;
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic signed [POS_W-1:0] pos_z;
   } req_payload_type;

   // Result transaction
   typedef struct packed {
      status_type              status;
      logic signed [POS_W-1:0] out_x;
      logic signed [POS_W-1:0] out_y;
      logic signed [POS_W-1:0] out_z;
   } rsp_payload_type;

endpackage

`default_nettype wire

>>> design/jump_confirmed_position_filter.sv
// ----------------------------------------------------------------------------
// Jump-confirmed position filter
// Publishes 3-axis target positions, holding back large jumps until they are
// confirmed by consecutive nearby readings.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one position transaction (target_present, pos_x/y/z);
//   rsp_* returns one status transaction per request with the last published
//   position. Both use valid/ready. csr_* is an APB-style port holding the
//   change tolerance, jump threshold, candidate tolerance and confirmation
//   count at byte addresses 0x0, 0x4, 0x8 and 0xC.
//   A request is captured in the input register; the decision, squared
//   distance compares and state update are combinational on the input
//   register and land in the result register when it advances.
//   Throughput is one transaction per cycle while results are taken, set by
//   the state update between the input and result registers.
//   When rsp_ready is low the result register holds; the input register still
//   takes one more transaction, then req_ready drops until the result drains.
//   Reset clears the pipeline, the published and pending positions and the
//   confirmation count, and loads the register reset values. Registers must
//   only be written while no transaction is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module jump_confirmed_position_filter (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // request channel
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire jcpf_pkg::req_payload_type     req_data,
   // result channel
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output jcpf_pkg::rsp_payload_type          rsp_data,
   // configuration port
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [jcpf_pkg::CSR_AW-1:0]   csr_paddr,
   input  wire logic [jcpf_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [jcpf_pkg::CSR_DW-1:0]        csr_prdata,
   output logic                               csr_pready
);
   import jcpf_pkg::*;

   localparam int DIFF_W = POS_W + 1;
   localparam int CMP_W  = (DIFF_W > TOL_W) ? DIFF_W : TOL_W;

   // configuration registers
   logic [TOL_W-1:0] change_tol_ff;
   logic [TOL_W-1:0] jump_thr_ff;
   logic [TOL_W-1:0] cand_tol_ff;
   logic [CNT_W-1:0] req_conf_ff;
   logic [SQ_W-1:0]  jump_thr_sq_ff;
   logic [SQ_W-1:0]  cand_tol_sq_ff;
   logic             csr_write;
   csr_index_type    csr_index;
   logic [TOL_W-1:0] csr_tol_data;

   // pipeline registers
   logic             in_valid_ff, in_valid_in;
   req_payload_type  in_data_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_payload_type  rsp_data_ff;
   logic             req_fire;
   logic             advance;

   // filter state
   logic signed [POS_W-1:0] last_ff [3];
   logic signed [POS_W-1:0] last_in [3];
   logic signed [POS_W-1:0] pend_ff [3];
   logic signed [POS_W-1:0] pend_in [3];
   logic [CNT_W-1:0]        confirm_count_ff, confirm_count_in;
   logic                    published_once_ff, published_once_in;

   // datapath
   logic signed [POS_W-1:0]  pos [3];
   logic signed [DIFF_W-1:0] diff_last [3];
   logic signed [DIFF_W-1:0] diff_pend [3];
   logic [DIFF_W-1:0]        mag_last [3];
   logic [DIFF_W-1:0]        mag_pend [3];
   logic [CMP_W-1:0]         mag_last_ext [3];
   logic [CMP_W-1:0]         mag_pend_ext [3];
   logic [TOL_W-1:0]         mag_last_nar [3];
   logic [TOL_W-1:0]         mag_pend_nar [3];
   logic [SQ_W-1:0]          sq_last [3];
   logic [SQ_W-1:0]          sq_pend [3];
   logic [SUM_W-1:0]         sum_last;
   logic [SUM_W-1:0]         sum_pend;
   logic                     changed;
   logic                     axis_far_last;
   logic                     axis_far_pend;
   logic                     far_last;
   logic                     far_pend;
   logic [CNT_W-1:0]         count_inc;
   logic                     publish;
   status_type               status;

   // ------------------------------------------------------------------------
   // Configuration port
   // ------------------------------------------------------------------------
   assign csr_pready   = 1'b1;
   assign csr_write    = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index    = csr_index_type'(csr_paddr[3:2]);
   assign csr_tol_data = csr_pwdata[TOL_W-1:0];

   // squared thresholds are kept alongside the raw values
   always_ff @(posedge clock) begin
      if (reset) begin
         change_tol_ff  <= CHANGE_TOL_RESET;
         jump_thr_ff    <= JUMP_THR_RESET;
         cand_tol_ff    <= CAND_TOL_RESET;
         req_conf_ff    <= REQ_CONF_RESET;
         jump_thr_sq_ff <= JUMP_THR_SQ_RESET;
         cand_tol_sq_ff <= CAND_TOL_SQ_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_CHANGE_TOL: change_tol_ff <= csr_tol_data;
            REG_JUMP_THR: begin
               jump_thr_ff    <= csr_tol_data;
               jump_thr_sq_ff <= SQ_W'(csr_tol_data) * SQ_W'(csr_tol_data);
            end
            REG_CAND_TOL: begin
               cand_tol_ff    <= csr_tol_data;
               cand_tol_sq_ff <= SQ_W'(csr_tol_data) * SQ_W'(csr_tol_data);
            end
            REG_REQ_CONF: req_conf_ff <= csr_pwdata[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   // register readback
   always_comb begin
      case (csr_index)
         REG_CHANGE_TOL: csr_prdata = CSR_DW'(change_tol_ff);
         REG_JUMP_THR:   csr_prdata = CSR_DW'(jump_thr_ff);
         REG_CAND_TOL:   csr_prdata = CSR_DW'(cand_tol_ff);
         REG_REQ_CONF:   csr_prdata = CSR_DW'(req_conf_ff);
         default:        csr_prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------------
   // Handshake and pipeline control
   // ------------------------------------------------------------------------
   assign advance     = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready   = !in_valid_ff || advance;
   assign req_fire    = req_valid && req_ready;
   assign in_valid_in = req_fire || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_data_ff <= req_data;
      end
   end

   // ------------------------------------------------------------------------
   // Per-axis differences, magnitudes and squares
   // ------------------------------------------------------------------------
   assign pos[0] = in_data_ff.pos_x;
   assign pos[1] = in_data_ff.pos_y;
   assign pos[2] = in_data_ff.pos_z;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         diff_last[i] = DIFF_W'(pos[i]) - DIFF_W'(last_ff[i]);
         diff_pend[i] = DIFF_W'(pos[i]) - DIFF_W'(pend_ff[i]);
         mag_last[i]  = diff_last[i][DIFF_W-1] ? DIFF_W'(-diff_last[i])
                                               : DIFF_W'(diff_last[i]);
         mag_pend[i]  = diff_pend[i][DIFF_W-1] ? DIFF_W'(-diff_pend[i])
                                               : DIFF_W'(diff_pend[i]);
         mag_last_ext[i] = CMP_W'(mag_last[i]);
         mag_pend_ext[i] = CMP_W'(mag_pend[i]);
         // only used when the axis is within a 23-bit limit
         mag_last_nar[i] = mag_last_ext[i][TOL_W-1:0];
         mag_pend_nar[i] = mag_pend_ext[i][TOL_W-1:0];
         sq_last[i] = SQ_W'(mag_last_nar[i]) * SQ_W'(mag_last_nar[i]);
         sq_pend[i] = SQ_W'(mag_pend_nar[i]) * SQ_W'(mag_pend_nar[i]);
      end
   end

   // ------------------------------------------------------------------------
   // Distance compares: one axis past the limit decides on its own
   // ------------------------------------------------------------------------
   always_comb begin
      changed       = !published_once_ff;
      axis_far_last = 1'b0;
      axis_far_pend = 1'b0;
      for (int i = 0; i < 3; i++) begin
         if (mag_last_ext[i] > CMP_W'(change_tol_ff)) changed = 1'b1;
         if (mag_last_ext[i] > CMP_W'(jump_thr_ff))   axis_far_last = 1'b1;
         if (mag_pend_ext[i] > CMP_W'(cand_tol_ff))   axis_far_pend = 1'b1;
      end
      sum_last = SUM_W'(sq_last[0]) + SUM_W'(sq_last[1]) + SUM_W'(sq_last[2]);
      sum_pend = SUM_W'(sq_pend[0]) + SUM_W'(sq_pend[1]) + SUM_W'(sq_pend[2]);
      far_last = axis_far_last || (sum_last > SUM_W'(jump_thr_sq_ff));
      far_pend = axis_far_pend || (sum_pend > SUM_W'(cand_tol_sq_ff));
   end

   // ------------------------------------------------------------------------
   // Decision and next state
   // ------------------------------------------------------------------------
   assign count_inc = (confirm_count_ff == CNT_MAX) ? CNT_MAX
                                                    : confirm_count_ff + CNT_W'(1);

   always_comb begin
      publish           = 1'b0;
      status            = STATUS_NO_TARGET;
      confirm_count_in  = confirm_count_ff;
      published_once_in = published_once_ff;
      for (int i = 0; i < 3; i++) begin
         last_in[i] = last_ff[i];
         pend_in[i] = pend_ff[i];
      end

      if (!in_data_ff.target_present) begin
         status = STATUS_NO_TARGET;
      end else if (!changed) begin
         status = STATUS_UNCHANGED;
      end else if (published_once_ff && far_last) begin
         if (far_pend) begin
            // large jump away from the candidate: start a new one
            for (int i = 0; i < 3; i++) begin
               pend_in[i] = pos[i];
            end
            confirm_count_in = CNT_W'(1);
            status           = STATUS_NEW_CANDIDATE;
         end else begin
            confirm_count_in = count_inc;
            if (count_inc < req_conf_ff) begin
               status = STATUS_CONFIRMING;
            end else begin
               publish = 1'b1;
               status  = STATUS_PUBLISHED;
            end
         end
      end else begin
         publish = 1'b1;
         status  = STATUS_PUBLISHED;
      end

      if (publish) begin
         for (int i = 0; i < 3; i++) begin
            last_in[i] = pos[i];
            pend_in[i] = pos[i];
         end
         confirm_count_in  = '0;
         published_once_in = 1'b1;
      end
   end

   // state registers, updated as each transaction leaves the input register
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            last_ff[i] <= '0;
            pend_ff[i] <= '0;
         end
         confirm_count_ff  <= '0;
         published_once_ff <= 1'b0;
      end else if (advance) begin
         for (int i = 0; i < 3; i++) begin
            last_ff[i] <= last_in[i];
            pend_ff[i] <= pend_in[i];
         end
         confirm_count_ff  <= confirm_count_in;
         published_once_ff <= published_once_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff.status <= status;
         rsp_data_ff.out_x  <= last_in[0];
         rsp_data_ff.out_y  <= last_in[1];
         rsp_data_ff.out_z  <= last_in[2];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
`ifndef NO_ASSERTIONS
   // a published result carries the position of the transaction that caused it
   a_publish_output: assert property (@(posedge clock) disable iff (reset)
      advance && publish |=> rsp_data.out_x == $past(in_data_ff.pos_x)
                          && rsp_data.out_y == $past(in_data_ff.pos_y)
                          && rsp_data.out_z == $past(in_data_ff.pos_z))
      else $error("published result does not match its input position");

   // a publish clears the confirmation count and marks the first publish
   a_publish_state: assert property (@(posedge clock) disable iff (reset)
      advance && publish |=> confirm_count_ff == '0 && published_once_ff)
      else $error("publish did not reset confirmation state");

   // a new candidate restarts the count at one
   a_new_candidate: assert property (@(posedge clock) disable iff (reset)
      advance && status == STATUS_NEW_CANDIDATE |=> confirm_count_ff == CNT_W'(1))
      else $error("new candidate did not restart the count");

   // without a publish the last published position does not move
   a_hold_last: assert property (@(posedge clock) disable iff (reset)
      advance && !publish |=> $stable(last_ff[0]) && $stable(last_ff[1])
                           && $stable(last_ff[2]))
      else $error("last position changed without a publish");
`endif

endmodule

`default_nettype wire

>>> tb/jump_confirmed_position_filter_tb.sv
// ----------------------------------------------------------------------------
// Jump-confirmed position filter testbench
// Drives position transactions through the filter and checks each status
// transaction against a cycle-free model of the publish / jump-confirm
// decision. A directed table covers reset values, field extremes and every
// status code. Random phases then sweep the registers, from zero to full
// scale, with random idling on both channels and one long result back-pressure.
// ----------------------------------------------------------------------------
`default_nettype none

module jump_confirmed_position_filter_tb;
   import jcpf_pkg::*;

   localparam int HALF_PERIOD    = 6;
   localparam int RESET_CYCLES   = 9;
   localparam int PHASE_ITEMS    = 170;
   localparam int PHASES         = 7;
   localparam int RX_HOLD_CYCLES = 80;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 4;
   localparam int DIR_ROWS       = 24;

   // One directed row: stimulus plus an optional hand-written expectation
   typedef struct {
      req_payload_type req;
      bit              typed;
      rsp_payload_type rsp;
   } dir_row_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   req_payload_type       req_data;
   logic                  rsp_valid;
   logic                  rsp_ready;
   rsp_payload_type       rsp_data;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_AW-1:0]     csr_paddr;
   logic [CSR_DW-1:0]     csr_pwdata;
   logic [CSR_DW-1:0]     csr_prdata;
   logic                  csr_pready;

   // Filter model state and register copy
   longint                pub_pos [3];
   longint                cand_pos [3];
   int                    cand_hits;
   bit                    has_published;
   int unsigned           cfg_val [4];

   // Status transactions still to come back, oldest first
   rsp_payload_type       due_reports [$];

   // Random jump sequence in progress
   int                    seq_left;
   longint                seq_mid [3];

   bit                    tx_no_idle;
   bit                    rx_no_idle;
   int                    rx_holds_asked;
   int                    rx_holds_done;
   int                    fail_count;
   int                    stall_cycles;

   dir_row_type dir_table [DIR_ROWS] = '{
      // absent target before any publish
      '{'{1'b0, 24'h7FFFFF, 24'h800000, 24'h123456}, 1'b1,
        '{STATUS_NO_TARGET, 24'sd0, 24'sd0, 24'sd0}},
      // first present reading publishes at once
      '{'{1'b1, 24'sd0, 24'sd0, 24'sd0}, 1'b1,
        '{STATUS_PUBLISHED, 24'sd0, 24'sd0, 24'sd0}},
      '{'{1'b1, 24'sd100, -24'sd100, 24'sd0}, 1'b1,
        '{STATUS_UNCHANGED, 24'sd0, 24'sd0, 24'sd0}},
      // change exactly at the tolerance, then one past it
      '{'{1'b1, 24'sd655, 24'sd0, 24'sd0}, 1'b1,
        '{STATUS_UNCHANGED, 24'sd0, 24'sd0, 24'sd0}},
      '{'{1'b1, 24'sd656, 24'sd0, 24'sd0}, 1'b1,
        '{STATUS_PUBLISHED, 24'sd656, 24'sd0, 24'sd0}},
      // large jump confirmed by two more nearby readings
      '{'{1'b1, 24'sd40656, 24'sd0, 24'sd0}, 1'b1,
        '{STATUS_NEW_CANDIDATE, 24'sd656, 24'sd0, 24'sd0}},
      '{'{1'b1, 24'sd40756, 24'sd0, 24'sd0}, 1'b1,
        '{STATUS_CONFIRMING, 24'sd656, 24'sd0, 24'sd0}},
      '{'{1'b1, 24'sd40656, 24'sd0, 24'sd0}, 1'b1,
        '{STATUS_PUBLISHED, 24'sd40656, 24'sd0, 24'sd0}},
      // full-scale positions, absent reading in the middle of a confirmation
      '{'{1'b1, 24'h7FFFFF, 24'h800000, 24'h7FFFFF}, 1'b1,
        '{STATUS_NEW_CANDIDATE, 24'sd40656, 24'sd0, 24'sd0}},
      '{'{1'b0, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF}, 1'b1,
        '{STATUS_NO_TARGET, 24'sd40656, 24'sd0, 24'sd0}},
      '{'{1'b1, 24'h7FFFFF, 24'h800000, 24'h7FFFFF}, 1'b1,
        '{STATUS_CONFIRMING, 24'sd40656, 24'sd0, 24'sd0}},
      '{'{1'b1, 24'h7FFFFF, 24'h800000, 24'h7FFFFF}, 1'b1,
        '{STATUS_PUBLISHED, 24'h7FFFFF, 24'h800000, 24'h7FFFFF}},
      '{'{1'b1, 24'h800000, 24'h7FFFFF, 24'h800000}, 1'b1,
        '{STATUS_NEW_CANDIDATE, 24'h7FFFFF, 24'h800000, 24'h7FFFFF}},
      '{'{1'b0, 24'sd0, 24'sd0, 24'sd0}, 1'b1,
        '{STATUS_NO_TARGET, 24'h7FFFFF, 24'h800000, 24'h7FFFFF}},
      // back to the origin
      '{'{1'b1, 24'sd0, 24'sd0, 24'sd0}, 1'b0, '0},
      '{'{1'b1, 24'sd0, 24'sd0, 24'sd0}, 1'b0, '0},
      '{'{1'b1, 24'sd0, 24'sd0, 24'sd0}, 1'b0, '0},
      // every axis under the jump threshold, but the distance over it
      '{'{1'b1, 24'sd20000, 24'sd20000, 24'sd20000}, 1'b0, '0},
      '{'{1'b1, 24'sd18000, 24'sd18000, 24'sd18000}, 1'b0, '0},
      '{'{1'b1, 24'sd25000, 24'sd25000, 24'sd25000}, 1'b0, '0},
      // candidate distance over tolerance though every axis is under it
      '{'{1'b1, 24'sd65000, 24'sd25000, 24'sd25000}, 1'b0, '0},
      '{'{1'b1, 24'sd73000, 24'sd33000, 24'sd33000}, 1'b0, '0},
      '{'{1'b1, 24'sd80000, 24'sd40000, 24'sd40000}, 1'b0, '0},
      '{'{1'b1, 24'sd73000, 24'sd33000, 24'sd33000}, 1'b0, '0}
   };

   jump_confirmed_position_filter i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #HALF_PERIOD clock = ~clock;

   // ----- filter model -----

   function automatic longint axis_gap(input longint a, input longint b);
      return (a > b) ? a - b : b - a;
   endfunction

   // Distance from a to b over lim; an axis over lim decides on its own
   function automatic bit beyond(input longint a [3], input longint b [3],
                                 input longint lim);
      longint gap;
      longint acc;
      acc = 0;
      for (int i = 0; i < 3; i++) begin
         gap = axis_gap(a[i], b[i]);
         if (gap > lim)
            return 1'b1;
         acc += gap * gap;
      end
      return acc > lim * lim;
   endfunction

   // Decide on one reading, update the model and return its status transaction
   function automatic rsp_payload_type track_position(input req_payload_type r);
      rsp_payload_type res;
      longint          p [3];
      bit              moved;
      bit              commit;
      p[0] = $signed(r.pos_x);
      p[1] = $signed(r.pos_y);
      p[2] = $signed(r.pos_z);
      commit = 1'b0;
      res.status = STATUS_NO_TARGET;
      if (r.target_present) begin
         moved = !has_published;
         for (int i = 0; i < 3; i++)
            if (axis_gap(p[i], pub_pos[i]) > longint'(cfg_val[REG_CHANGE_TOL]))
               moved = 1'b1;
         if (!moved) begin
            res.status = STATUS_UNCHANGED;
         end else if (has_published &&
                      beyond(p, pub_pos, longint'(cfg_val[REG_JUMP_THR]))) begin
            if (beyond(p, cand_pos, longint'(cfg_val[REG_CAND_TOL]))) begin
               cand_pos = p;
               cand_hits = 1;
               res.status = STATUS_NEW_CANDIDATE;
            end else begin
               if (cand_hits < int'(CNT_MAX))
                  cand_hits++;
               if (cand_hits < int'(cfg_val[REG_REQ_CONF])) begin
                  res.status = STATUS_CONFIRMING;
               end else begin
                  commit = 1'b1;
                  res.status = STATUS_PUBLISHED;
               end
            end
         end else begin
            commit = 1'b1;
            res.status = STATUS_PUBLISHED;
         end
      end
      if (commit) begin
         pub_pos = p;
         cand_pos = p;
         cand_hits = 0;
         has_published = 1'b1;
      end
      res.out_x = POS_W'(pub_pos[0]);
      res.out_y = POS_W'(pub_pos[1]);
      res.out_z = POS_W'(pub_pos[2]);
      return res;
   endfunction

   // ----- stimulus -----

   function automatic longint jitter(input longint span);
      return longint'($urandom_range(0, 32'(2 * span))) - span;
   endfunction

   function automatic logic [POS_W-1:0] pos_clip(input longint v);
      if (v > 64'sd8388607)
         return 24'h7FFFFF;
      if (v < -64'sd8388608)
         return 24'h800000;
      return POS_W'(v);
   endfunction

   // Next random reading, shaped around the current published position
   function automatic req_payload_type next_item();
      req_payload_type it;
      longint          q [3];
      int unsigned     dice;
      int              ax;
      longint          reach;
      it = '0;
      it.target_present = 1'b1;
      q = pub_pos;
      dice = $urandom_range(99);
      if (seq_left > 0) begin
         // readings around a pending jump, some of them noise
         seq_left--;
         if (dice < 10) begin
            for (int i = 0; i < 3; i++)
               q[i] = $signed(POS_W'($urandom));
         end else begin
            for (int i = 0; i < 3; i++)
               q[i] = seq_mid[i] + jitter(cfg_val[REG_CAND_TOL] / 2);
         end
      end else if (dice < 8) begin
         it.target_present = 1'b0;
         for (int i = 0; i < 3; i++)
            q[i] = $signed(POS_W'($urandom));
      end else if (dice < 16) begin
         for (int i = 0; i < 3; i++)
            q[i] = $signed(POS_W'($urandom));
      end else if (dice < 32) begin
         for (int i = 0; i < 3; i++)
            q[i] = pub_pos[i] + jitter(cfg_val[REG_CHANGE_TOL]);
      end else if (dice < 55) begin
         for (int i = 0; i < 3; i++)
            q[i] = pub_pos[i] + jitter(cfg_val[REG_JUMP_THR]);
      end else begin
         // start a jump and follow it with a run of nearby readings
         ax = $urandom_range(2);
         reach = longint'(cfg_val[REG_JUMP_THR]) + 1 +
                 longint'($urandom_range(0, cfg_val[REG_JUMP_THR]));
         for (int i = 0; i < 3; i++)
            q[i] = pub_pos[i] + jitter(cfg_val[REG_CAND_TOL] / 4);
         q[ax] = $urandom_range(1) ? pub_pos[ax] + reach : pub_pos[ax] - reach;
         for (int i = 0; i < 3; i++)
            seq_mid[i] = $signed(pos_clip(q[i]));
         seq_left = $urandom_range(0, cfg_val[REG_REQ_CONF] + 1);
      end
      it.pos_x = pos_clip(q[0]);
      it.pos_y = pos_clip(q[1]);
      it.pos_z = pos_clip(q[2]);
      return it;
   endfunction

   // Offer one transaction, with a random gap first, and log its expectation
   task automatic offer(input req_payload_type item, input bit typed,
                        input rsp_payload_type typed_rsp);
      rsp_payload_type want;
      while (!tx_no_idle && $urandom_range(99) < 32) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (!req_ready);
      want = track_position(item);
      due_reports.push_back(typed ? typed_rsp : want);
   endtask

   // Stop offering and wait for every outstanding result
   task automatic settle();
      req_valid <= 1'b0;
      while (due_reports.size() != 0)
         @(posedge clock);
   endtask

   // ----- register port -----

   task automatic csr_access(input bit wr, input csr_index_type idx,
                             input logic [CSR_DW-1:0] wdata,
                             output logic [CSR_DW-1:0] rdata);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= wr;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic read_back(input csr_index_type idx);
      logic [CSR_DW-1:0] rd;
      csr_access(1'b0, idx, '0, rd);
      if (rd !== CSR_DW'(cfg_val[idx])) begin
         $error("register %s: expected %0d, got %0d", idx.name(), cfg_val[idx], rd);
         fail_count++;
      end
   endtask

   // Write all four registers, junk in the unused upper bits, and read back
   task automatic program_regs(input int unsigned vals [4]);
      logic [CSR_DW-1:0] rd;
      csr_index_type     idx;
      int                w;
      for (int k = 0; k < 4; k++) begin
         idx = csr_index_type'(k);
         w = (idx == REG_REQ_CONF) ? CNT_W : TOL_W;
         cfg_val[k] = vals[k] & ((32'd1 << w) - 1);
         csr_access(1'b1, idx, (CSR_DW'($urandom) << w) | cfg_val[k], rd);
         read_back(idx);
      end
   endtask

   // ----- result side -----

   // Ready with random idling; a requested hold keeps it low for a long stretch
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (rx_holds_asked != rx_holds_done) begin
            rx_holds_done++;
            rsp_ready <= 1'b0;
            repeat (RX_HOLD_CYCLES) @(posedge clock);
         end
         rsp_ready <= rx_no_idle || ($urandom_range(99) >= 32);
      end
   end

   // Compare each accepted result with the oldest expectation
   always @(posedge clock) begin
      rsp_payload_type exp_rsp;
      if (!reset && rsp_valid && rsp_ready) begin
         if (due_reports.size() == 0) begin
            $error("unexpected result transaction: status %0d", rsp_data.status);
            fail_count++;
         end else begin
            exp_rsp = due_reports.pop_front();
            if (rsp_data.status !== exp_rsp.status) begin
               $error("status: expected %0d, got %0d", exp_rsp.status, rsp_data.status);
               fail_count++;
            end
            if (rsp_data.out_x !== exp_rsp.out_x) begin
               $error("out_x: expected %0d, got %0d",
                      $signed(exp_rsp.out_x), $signed(rsp_data.out_x));
               fail_count++;
            end
            if (rsp_data.out_y !== exp_rsp.out_y) begin
               $error("out_y: expected %0d, got %0d",
                      $signed(exp_rsp.out_y), $signed(rsp_data.out_y));
               fail_count++;
            end
            if (rsp_data.out_z !== exp_rsp.out_z) begin
               $error("out_z: expected %0d, got %0d",
                      $signed(exp_rsp.out_z), $signed(rsp_data.out_z));
               fail_count++;
            end
         end
      end
   end

   // Watchdog on cycles with no transaction accepted on any port
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_psel && csr_penable && csr_pready)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   // ----- main sequence -----

   initial begin
      int unsigned regs [4];
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      tx_no_idle = 1'b0;
      rx_no_idle = 1'b0;
      rx_holds_asked = 0;
      rx_holds_done = 0;
      fail_count = 0;
      stall_cycles = 0;
      seq_left = 0;
      seq_mid = '{0, 0, 0};
      pub_pos = '{0, 0, 0};
      cand_pos = '{0, 0, 0};
      cand_hits = 0;
      has_published = 1'b0;
      cfg_val[REG_CHANGE_TOL] = CHANGE_TOL_RESET;
      cfg_val[REG_JUMP_THR] = JUMP_THR_RESET;
      cfg_val[REG_CAND_TOL] = CAND_TOL_RESET;
      cfg_val[REG_REQ_CONF] = REQ_CONF_RESET;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // register reset values
      for (int k = 0; k < 4; k++)
         read_back(csr_index_type'(k));

      // directed table
      foreach (dir_table[k])
         offer(dir_table[k].req, dir_table[k].typed, dir_table[k].rsp);

      // random phases, each under its own register setting
      for (int ph = 0; ph < PHASES; ph++) begin
         settle();
         tx_no_idle = 1'b0;
         rx_no_idle = 1'b0;
         case (ph)
            1: regs = '{0, 0, 0, 1};
            2: regs = '{8388607, 8388607, 8388607, 255};
            3: regs = '{655, 32768, 13107, 0};
            4, 6: regs = '{$urandom_range(0, 2000), $urandom_range(1000, 200000),
                           $urandom_range(0, 50000), $urandom_range(1, 8)};
            default: regs = '{655, 32768, 13107, 3};
         endcase
         program_regs(regs);
         seq_left = 0;
         // long stretch with no idling on either side
         if (ph == 4) begin
            tx_no_idle = 1'b1;
            rx_no_idle = 1'b1;
         end
         // sender keeps offering while the receiver holds off
         if (ph == 5)
            tx_no_idle = 1'b1;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (ph == 5 && n == 30)
               rx_holds_asked++;
            offer(next_item(), 1'b0, '0);
         end
      end

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

`default_nettype wire

>>> filelist.f
design/jcpf_pkg.sv
design/jump_confirmed_position_filter.sv
tb/jump_confirmed_position_filter_tb.sv
